// File: rtl/core/itab_pkg.sv
// Shared types and constants for the interpolation lookup table.
package itab_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int MIN_POINTS = 2;
  localparam logic [15:0] Y_MAX = 16'hFFFF;
  localparam int DIV_STEPS = 32;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } itab_kind_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } itab_point_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } itab_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [15:0] remainder;
  } itab_div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_CHK_LO,
    ST_CHK_HI,
    ST_SCAN,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RESULT
  } itab_state_t;

endpackage

// File: rtl/core/itab_mem.sv
// Breakpoint memory: one write port, one read port with registered data.
module itab_mem
  import itab_pkg::*;
#(
  parameter int DEPTH = MAX_POINTS_DEF,
  parameter int AW = $clog2(MAX_POINTS_DEF)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  itab_point_t   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output itab_point_t   rd_data
);

  itab_point_t mem_r [DEPTH];
  itab_point_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/itab_div.sv
// Restoring divider, one quotient bit per cycle.
module itab_div
  import itab_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  itab_div_req_t req,
  output itab_div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_STEPS);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   quo_r;
  logic [15:0]   rem_r;
  logic [15:0]   den_r;
  logic [16:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[31]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      den_r <= req.divisor;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so 16 bits hold it after the subtract.
      rem_r <= fits ? 16'(trial - {1'b0, den_r}) : trial[15:0];
      quo_r <= {quo_r[30:0], fits};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// File: rtl/core/itab_ctrl.sv
// Query sequencer: clamps, scans the table for the segment and forms the result.
module itab_ctrl
  import itab_pkg::*;
#(
  parameter int AW = $clog2(MAX_POINTS_DEF),
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [15:0]      query,
  input  logic [CNT_W-1:0] n_eff,
  output logic             idle,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  input  itab_point_t      rd_data,
  output itab_div_req_t    div_req,
  input  itab_div_rsp_t    div_rsp,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [15:0]      res_data
);

  itab_state_t state_r, state_nxt;

  logic [15:0]   q_r;
  logic [AW-1:0] last_r;
  logic [AW-1:0] idx_r;
  logic [15:0]   x0_r, y0_r, x1_r, y1_r;
  logic [31:0]   prod_r;
  logic          neg_r;
  logic [15:0]   res_r;

  logic          in_seg;
  logic [17:0]   val;
  logic [15:0]   val_sat;
  logic [15:0]   dy_mag;
  logic [15:0]   dx;

  assign in_seg = (x0_r <= q_r) && (q_r <= rd_data.x);
  assign dy_mag = (y1_r >= y0_r) ? (y1_r - y0_r) : (y0_r - y1_r);
  assign dx     = q_r - x0_r;

  // Floor division: a negative slope rounds the magnitude up.
  always_comb begin
    if (neg_r) begin
      val = {2'b00, y0_r} - {2'b00, div_rsp.quotient[15:0]}
            - {17'b0, div_rsp.remainder != 16'd0};
    end else begin
      val = {2'b00, y0_r} + {2'b00, div_rsp.quotient[15:0]};
    end
    if (val[17]) begin
      val_sat = 16'd0;
    end else if (val[16]) begin
      val_sat = Y_MAX;
    end else begin
      val_sat = val[15:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (n_eff < CNT_W'(MIN_POINTS)) ? ST_RESULT : ST_RD_LO;
        end
      end
      ST_RD_LO:  state_nxt = ST_CHK_LO;
      ST_CHK_LO: state_nxt = (q_r < rd_data.x) ? ST_RESULT : ST_CHK_HI;
      ST_CHK_HI: state_nxt = (q_r > rd_data.x) ? ST_RESULT : ST_SCAN;
      ST_SCAN: begin
        if (in_seg) begin
          state_nxt = (rd_data.x == x0_r) ? ST_RESULT : ST_MUL;
        end else if (idx_r == last_r) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_MUL:    state_nxt = ST_DIV_GO;
      ST_DIV_GO: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idle             = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = '0;
    res_valid        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_r;
    div_req.divisor  = x1_r - x0_r;
    unique case (state_r)
      ST_IDLE: idle = 1'b1;
      ST_RD_LO: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      ST_CHK_LO: begin
        rd_en   = 1'b1;
        rd_addr = last_r;
      end
      ST_CHK_HI: begin
        rd_en   = 1'b1;
        rd_addr = AW'(1);
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = idx_r + AW'(1);
      end
      ST_DIV_GO: div_req.start = 1'b1;
      ST_RESULT: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          q_r    <= query;
          last_r <= AW'(n_eff - CNT_W'(1));
          res_r  <= 16'd0;
        end
      end
      ST_CHK_LO: begin
        x0_r  <= rd_data.x;
        y0_r  <= rd_data.y;
        res_r <= rd_data.y;
      end
      ST_CHK_HI: begin
        idx_r <= AW'(1);
        res_r <= rd_data.y;
      end
      ST_SCAN: begin
        if (in_seg) begin
          x1_r  <= rd_data.x;
          y1_r  <= rd_data.y;
          res_r <= y0_r;
        end else begin
          x0_r  <= rd_data.x;
          y0_r  <= rd_data.y;
          idx_r <= idx_r + AW'(1);
          res_r <= 16'd0;
        end
      end
      ST_MUL: begin
        prod_r <= dy_mag * dx;
        neg_r  <= y1_r < y0_r;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          res_r <= val_sat;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/interp_table_u16_to_u16.sv
// Top level of the piecewise-linear interpolation lookup table.
//
//   Channel  Signals                                          Direction
//   in       in_valid/in_ready, in_kind, in_entry_index,      input
//            in_point_x, in_point_y, in_query
//   out      out_valid/out_ready, out_result                  output
//   cfg      cfg_wr_en, cfg_wr_data (point_count)             input
//
// A breakpoint write is written into the memory at acceptance.
// A query clamped at either table end skips the scan. An interpolated query scans up
// to its segment (one memory read per breakpoint scanned) and then waits on the
// bit-serial divider.
// Reset is synchronous and clears control state only; the table is undefined until written.
// A stalled result sits in the output register while the next transaction is accepted.
module interp_table_u16_to_u16
  import itab_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [3:0]  in_entry_index,
  input  logic [15:0] in_point_x,
  input  logic [15:0] in_point_y,
  input  logic [15:0] in_query,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CNT_W = ($clog2(MAX_POINTS + 1) > 5) ? $clog2(MAX_POINTS + 1) : 5;

  logic [4:0]       point_count_r;
  logic [CNT_W-1:0] count_ext;
  logic [CNT_W-1:0] n_eff;
  logic             in_fire;
  logic             wr_en;
  itab_point_t      wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  itab_point_t      rd_data;
  itab_div_req_t    div_req;
  itab_div_rsp_t    div_rsp;
  logic             ctrl_idle;
  logic             res_valid;
  logic             res_ready;
  logic [15:0]      res_data;
  logic             out_valid_r;
  logic [15:0]      out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
    end else if (cfg_wr_en) begin
      point_count_r <= cfg_wr_data;
    end
  end

  assign count_ext = CNT_W'(point_count_r);
  assign n_eff     = (count_ext > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_ext;

  assign in_ready = ctrl_idle;
  assign in_fire  = in_valid && in_ready;
  // Writes to slots beyond the table depth are dropped.
  assign wr_en    = in_fire && (in_kind == KIND_WRITE)
                    && (CNT_W'(in_entry_index) < CNT_W'(MAX_POINTS));
  assign wr_data  = '{x: in_point_x, y: in_point_y};

  itab_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  itab_ctrl #(
    .AW    (AW),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire && (in_kind == KIND_QUERY)),
    .query     (in_query),
    .n_eff     (n_eff),
    .idle      (ctrl_idle),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  itab_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_result_r <= res_data;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// File: rtl/core/itab_chk.sv
// Port-level checks for the interpolation lookup table, bound to the top level.
module itab_chk
  import itab_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_result
);

  // The result register comes out of reset empty.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // A waiting result holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("stalled result changed");

  // A query transaction always makes the block busy, dropping ready in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_QUERY) |=> !in_ready)
    else $error("ready stayed high after a query");

  // A breakpoint write finishes at once and leaves the block ready.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_WRITE) |=> in_ready)
    else $error("ready dropped after a breakpoint write");

endmodule

bind interp_table_u16_to_u16 itab_chk u_chk (.*);

// File: tb/interp_table_u16_to_u16_tb.sv
// Self-checking testbench for the interpolation lookup table, with directed and random stimulus.
module interp_table_u16_to_u16_tb;
  import itab_pkg::*;

  localparam int TABLE_DEPTH = MAX_POINTS_DEF;
  localparam int DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int NUM_DIRECTED = 23;
  localparam int NUM_PHASES = 19;
  localparam int ITEMS_PER_PHASE = 90;

  typedef enum logic [1:0] {
    STEP_CONFIG,
    STEP_WRITE,
    STEP_QUERY
  } step_op_t;

  typedef struct packed {
    step_op_t    op;
    logic [4:0]  count;
    logic [3:0]  slot;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] q;
    logic        typed;
    logic [15:0] result;
  } lut_step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [3:0]  in_entry_index = 4'd0;
  logic [15:0] in_point_x = 16'd0;
  logic [15:0] in_point_y = 16'd0;
  logic [15:0] in_query = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_result;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = 5'd0;

  // Testbench copy of the breakpoint table and the point count.
  logic [15:0] bp_x [TABLE_DEPTH];
  logic [15:0] bp_y [TABLE_DEPTH];
  logic [4:0]  active_count = 5'd0;

  logic [15:0] pending_results [$];
  logic [15:0] wanted_result;
  int          mismatch_count = 0;
  int          send_idle_pct = 10;
  int          recv_idle_pct = 53;
  int unsigned cycle_count = 0;

  // Directed table. Rows with typed set carry their own expected result in place of the computed one.
  lut_step_t directed_steps [NUM_DIRECTED] = '{
    '{STEP_WRITE,  5'd0, 4'h0, 16'h0010, 16'd100,   16'hFFFF, 1'b0, 16'd0},
    '{STEP_WRITE,  5'd0, 4'h1, 16'h0010, 16'd900,   16'h0000, 1'b0, 16'd0},
    '{STEP_WRITE,  5'd0, 4'h2, 16'h0100, 16'd65535, 16'h0000, 1'b0, 16'd0},
    '{STEP_WRITE,  5'd0, 4'h3, 16'hFFF0, 16'd0,     16'h0000, 1'b0, 16'd0},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'h0000, 1'b1, 16'd0},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'hFFFF, 1'b1, 16'd0},
    '{STEP_CONFIG, 5'd1, 4'h0, 16'h0000, 16'h0000,  16'h0000, 1'b0, 16'd0},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'h0100, 1'b1, 16'd0},
    '{STEP_CONFIG, 5'd2, 4'h0, 16'h0000, 16'h0000,  16'h0000, 1'b0, 16'd0},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'h0000, 1'b1, 16'd100},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'h0011, 1'b1, 16'd900},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'h0010, 1'b1, 16'd100},
    '{STEP_CONFIG, 5'd4, 4'h0, 16'h0000, 16'h0000,  16'h0000, 1'b0, 16'd0},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'h0000, 1'b1, 16'd100},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'hFFFF, 1'b1, 16'd0},
    '{STEP_QUERY,  5'd0, 4'hF, 16'hFFFF, 16'hFFFF,  16'h0080, 1'b0, 16'd0},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'h0100, 1'b1, 16'd65535},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'h8000, 1'b0, 16'd0},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'hFFF0, 1'b1, 16'd0},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'h00FF, 1'b0, 16'd0},
    '{STEP_WRITE,  5'd0, 4'h3, 16'h0080, 16'd7,     16'h0000, 1'b0, 16'd0},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'h0090, 1'b0, 16'd0},
    '{STEP_QUERY,  5'd0, 4'h0, 16'h0000, 16'h0000,  16'h0050, 1'b0, 16'd0}
  };

  interp_table_u16_to_u16 i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_query       (in_query),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result     (out_result),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] lookup_expected(input logic [15:0] q);
    int     n;
    int     i;
    bit     found;
    longint x0, x1, y0, y1, num, den, quo, val;
    n = int'(active_count);
    found = 1'b0;
    x0 = 0; x1 = 0; y0 = 0; y1 = 0;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    if (n < MIN_POINTS) return 16'd0;
    if (q < bp_x[0]) return bp_y[0];
    if (q > bp_x[n-1]) return bp_y[n-1];
    // The first segment that brackets the query wins.
    for (i = 0; i + 1 < n; i++) begin
      if (!found && bp_x[i] <= q && q <= bp_x[i+1]) begin
        x0 = longint'(bp_x[i]);
        x1 = longint'(bp_x[i+1]);
        y0 = longint'(bp_y[i]);
        y1 = longint'(bp_y[i+1]);
        found = 1'b1;
      end
    end
    if (!found) return 16'd0;
    den = x1 - x0;
    if (den <= 0) return y0[15:0];
    num = (y1 - y0) * (longint'(q) - x0);
    // Falling segments round toward minus infinity.
    if (num >= 0) quo = num / den;
    else quo = -((-num + den - 1) / den);
    val = y0 + quo;
    if (val < 0) val = 0;
    if (val > 65535) val = 65535;
    return val[15:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic send_item(input itab_kind_t kind, input logic [3:0] slot,
                           input logic [15:0] px, input logic [15:0] py,
                           input logic [15:0] pq, input logic typed,
                           input logic [15:0] typed_result);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_entry_index <= slot;
    in_point_x     <= px;
    in_point_y     <= py;
    in_query       <= pq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == KIND_WRITE) begin
      bp_x[slot] = px;
      bp_y[slot] = py;
    end else begin
      pending_results.push_back(typed ? typed_result : lookup_expected(pq));
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // A write transaction gives no result, so leave room for one still in flight.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_point_count(input logic [4:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    active_count = value;
  endtask

  // Rewrites all entries with an ascending table; a zero step makes a zero-width segment.
  task automatic load_random_table();
    int s;
    int x_cur;
    int r;
    logic [15:0] yv;
    x_cur = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(255));
    for (s = 0; s < TABLE_DEPTH; s++) begin
      r = int'($urandom_range(7));
      if (r == 0) yv = 16'h0000;
      else if (r == 1) yv = 16'hFFFF;
      else yv = 16'($urandom);
      if (s == TABLE_DEPTH - 1 && $urandom_range(3) == 0) x_cur = 65535;
      send_item(KIND_WRITE, 4'(s), 16'(x_cur), yv, 16'($urandom), 1'b0, 16'd0);
      r = int'($urandom_range(7));
      if (r == 1) x_cur = x_cur;
      else if (r < 5) x_cur = x_cur + int'($urandom_range(300, 1));
      else x_cur = x_cur + int'($urandom_range(8000, 1));
      if (x_cur > 65535) x_cur = 65535;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d with no query outstanding", out_result));
        end else begin
          wanted_result = pending_results.pop_front();
          if (out_result !== wanted_result)
            report_mismatch($sformatf("result %0d, expected %0d", out_result, wanted_result));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int s;
    int p;
    int k;
    int r;
    int n_used;
    int lo;
    int hi;
    int mode;
    logic [4:0]  count_pick;
    logic [3:0]  sl;
    logic [15:0] xv;
    logic [15:0] qv;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (s = 0; s < NUM_DIRECTED; s++) begin
      case (directed_steps[s].op)
        STEP_CONFIG: begin
          write_point_count(directed_steps[s].count);
        end
        STEP_WRITE: begin
          send_item(KIND_WRITE, directed_steps[s].slot, directed_steps[s].x,
                    directed_steps[s].y, directed_steps[s].q, 1'b0, 16'd0);
        end
        default: begin
          send_item(KIND_QUERY, directed_steps[s].slot, directed_steps[s].x,
                    directed_steps[s].y, directed_steps[s].q, directed_steps[s].typed,
                    directed_steps[s].result);
        end
      endcase
    end

    // Every entry is written here, so no later query can read an unwritten slot.
    load_random_table();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: count_pick = 5'd16;
        1: count_pick = 5'd31;
        2: count_pick = 5'd2;
        3: count_pick = 5'd17;
        4: count_pick = 5'd0;
        5: count_pick = 5'd1;
        default: begin
          if ($urandom_range(4) != 0) count_pick = 5'($urandom_range(16, 2));
          else count_pick = 5'($urandom_range(31));
        end
      endcase
      write_point_count(count_pick);
      mode = (p * 3) / NUM_PHASES;
      send_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 53 : 0;
      recv_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 10 : 0;
      if ($urandom_range(1) == 1) load_random_table();

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(3) == 0) begin
          // Mostly keep the table ascending; the rest scrambles it.
          sl = 4'($urandom_range(15));
          lo = (sl == 4'd0) ? 0 : int'(bp_x[sl - 4'd1]);
          hi = (sl == 4'd15) ? 65535 : int'(bp_x[sl + 4'd1]);
          if ($urandom_range(3) != 0 && lo <= hi) xv = 16'($urandom_range(hi, lo));
          else xv = 16'($urandom);
          send_item(KIND_WRITE, sl, xv, 16'($urandom), 16'($urandom), 1'b0, 16'd0);
        end else begin
          n_used = (int'(active_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
          r = int'($urandom_range(99));
          if (r < 60 && n_used >= MIN_POINTS && bp_x[0] <= bp_x[n_used-1]) begin
            qv = 16'($urandom_range(int'(bp_x[n_used-1]), int'(bp_x[0])));
          end else if (r < 80) begin
            qv = bp_x[$urandom_range(TABLE_DEPTH - 1)];
            case ($urandom_range(2))
              0: qv = qv - 16'd1;
              1: qv = qv + 16'd1;
              default: qv = qv;
            endcase
          end else if (r < 85) begin
            qv = ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
          end else begin
            qv = 16'($urandom);
          end
          send_item(KIND_QUERY, 4'($urandom_range(15)), 16'($urandom), 16'($urandom), qv,
                    1'b0, 16'd0);
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
